// ----- rtl/tumf_pkg.sv -----
// shared constants, types and the unconditional pattern table
// for the thinning unconditional mask filter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tumf_pkg;

	localparam int DEF_MAX_WIDTH = 1024;

	localparam int PIX_W      = 8;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 16;
	localparam int ROW_W      = HEIGHT_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

	localparam int               RESET_WIDTH     = 1024;
	localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 16'd1024;
	localparam logic [PIX_W-1:0] RESET_THRESHOLD = 8'd127;
	localparam logic [PIX_W-1:0] PIX_ONE         = 8'd255;
	localparam logic [PIX_W-1:0] PIX_ZERO        = 8'd0;

	// window bit 3*row+col, row 0 is the oldest line
	localparam logic [8:0] SHIFT_KEEP  = 9'h0DB;
	localparam logic [8:0] MASK_LEFT   = 9'h049;
	localparam logic [8:0] MASK_RIGHT  = 9'h124;
	localparam logic [8:0] MASK_TOP    = 9'h007;
	localparam logic [8:0] MASK_BOTTOM = 9'h1C0;
	localparam int         CENTER_BIT  = 4;

	localparam int NUM_PATTERNS = 26;

	localparam logic [8:0] PAT_CARE [NUM_PATTERNS] = '{
		9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF,
		9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF,
		9'h01B, 9'h1B0,
		9'h03A, 9'h09A, 9'h0B8, 9'h0B2,
		9'h015, 9'h051, 9'h150, 9'h114,
		9'h0FE, 9'h1BB, 9'h0FE, 9'h1BB
	};

	localparam logic [8:0] PAT_ONES [NUM_PATTERNS] = '{
		9'h110, 9'h050, 9'h014, 9'h011, 9'h090, 9'h030, 9'h018, 9'h012,
		9'h032, 9'h01A, 9'h0B0, 9'h098,
		9'h01B, 9'h1B0,
		9'h03A, 9'h09A, 9'h0B8, 9'h0B2,
		9'h015, 9'h051, 9'h150, 9'h114,
		9'h072, 9'h11A, 9'h09C, 9'h0B1
	};

	// zero means no at-least-one group
	localparam logic [8:0] PAT_ANY [NUM_PATTERNS] = '{
		9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
		9'h000, 9'h000, 9'h000, 9'h000,
		9'h000, 9'h000,
		9'h000, 9'h000, 9'h000, 9'h000,
		9'h1C0, 9'h1A0, 9'h007, 9'h049,
		9'h000, 9'h000, 9'h000, 9'h000
	};

	typedef struct packed {
		logic emit;
		logic mbit;
		logic snew;
		logic first_col;
		logic last_col;
		logic first_row;
		logic last_row;
		logic last;
	} s1_ctrl_t;

	function automatic logic any_hit(input logic [8:0] w);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < NUM_PATTERNS; k++) begin
			if (((w & PAT_CARE[k]) == PAT_ONES[k]) &&
			    ((PAT_ANY[k] == 9'h000) || ((w & PAT_ANY[k]) != 9'h000))) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/tumf_stream_if.sv -----
// valid/ready stream interfaces for the pixel pairs and the result words
// depends on tumf_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface tumf_pix_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [tumf_pkg::PIX_W-1:0] marker_pixel;
	logic [tumf_pkg::PIX_W-1:0] original_pixel;

	modport source(output valid, action, marker_pixel, original_pixel, input ready);
	modport sink(input valid, action, marker_pixel, original_pixel, output ready);
endinterface

interface tumf_res_if;
	logic                       valid;
	logic                       ready;
	logic [tumf_pkg::PIX_W-1:0] out_pixel;
	logic                       last_of_frame;

	modport source(output valid, out_pixel, last_of_frame, input ready);
	modport sink(input valid, out_pixel, last_of_frame, output ready);
endinterface

`default_nettype wire

// ----- rtl/tumf_window.sv -----
// 3x3 marker window shift register, frame-edge masking and pattern match
// depends on tumf_pkg (pattern table, masks, stage control struct)
`timescale 1ns / 1ps
`default_nettype none

module tumf_window (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire tumf_pkg::s1_ctrl_t ctrl,
	input  wire logic [1:0]         line_bits,
	input  wire logic               delay_bit,
	output logic                    out_bit
);

	logic [8:0] win_q;
	logic [8:0] win_next;
	logic [8:0] win_masked;
	logic       top;
	logic       mid;

	always_comb begin
		// line bank of the current row parity holds the row two above
		top = ctrl.snew ? line_bits[1] : line_bits[0];
		mid = ctrl.snew ? line_bits[0] : line_bits[1];
		win_next = ((win_q >> 1) & tumf_pkg::SHIFT_KEEP) |
		           {ctrl.mbit, 2'b00, mid, 2'b00, top, 2'b00};

		win_masked = win_next;
		if (ctrl.first_col) begin
			win_masked = win_masked & ~tumf_pkg::MASK_LEFT;
		end
		if (ctrl.last_col) begin
			win_masked = win_masked & ~tumf_pkg::MASK_RIGHT;
		end
		if (ctrl.first_row) begin
			win_masked = win_masked & ~tumf_pkg::MASK_TOP;
		end
		if (ctrl.last_row) begin
			win_masked = win_masked & ~tumf_pkg::MASK_BOTTOM;
		end

		out_bit = delay_bit &&
		          (!win_masked[tumf_pkg::CENTER_BIT] || tumf_pkg::any_hit(win_masked));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (advance) begin
			win_q <= (ctrl.emit && ctrl.last) ? 9'h000 : win_next;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/thinning_unconditional_mask_filter.sv -----
// Unconditional-mask stage of morphological thinning on a raster stream.
// Channels: pixels (sink) carries action, marker_pixel, original_pixel;
// result (source) carries out_pixel (0 or 255) and last_of_frame.
// Config: cfg_wr_en / cfg_index / cfg_data, index 0 frame_width,
// 1 frame_height, 2 binary_threshold; write only between frames.
// Throughput: one pixel word per cycle unless the receiver stalls. Each
// word reads and writes the two-bank marker line memory and the
// original-pixel delay memory once, both read-first at one address, so
// words follow back to back. A word is registered in stage 1 and then in
// the output register; in the raster a result lags frame_width+1 words,
// so frame_width+1 pad words flush a frame. Pads inside a frame are
// dropped; after the last result all counters and the window restart.
// Reset clears counters, window and registers; memory contents stay
// undefined and are only read for rows outside the frame (no clear pass).
// When the receiver stalls the output register holds, the stage behind
// it holds, and pixels.ready drops only while both are full.
`timescale 1ns / 1ps
`default_nettype none

module thinning_unconditional_mask_filter #(
	parameter int MAX_WIDTH = tumf_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	tumf_pix_if.sink                            pixels,
	tumf_res_if.source                          result,
	input  wire logic                           cfg_wr_en,
	input  wire logic [tumf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tumf_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int PW = $clog2(MAX_WIDTH + 1);
	localparam int RESET_W = (tumf_pkg::RESET_WIDTH > MAX_WIDTH) ?
	                         MAX_WIDTH : tumf_pkg::RESET_WIDTH;
	localparam int RW = tumf_pkg::ROW_W;
	localparam int HW = tumf_pkg::HEIGHT_W;

	// configuration, kept in effective form
	logic [PW-1:0]              w_q;
	logic [CW-1:0]              wm1_q;
	logic [HW-1:0]              h_q;
	logic [HW-1:0]              hm1_q;
	logic [tumf_pkg::PIX_W-1:0] thr_q;

	logic [tumf_pkg::WIDTH_W-1:0] cfg_w_raw;
	logic [PW-1:0]                cfg_w_eff;
	logic [HW-1:0]                cfg_h_eff;

	always_comb begin
		cfg_w_raw = cfg_data[tumf_pkg::WIDTH_W-1:0];
		if (cfg_w_raw == '0) begin
			cfg_w_eff = PW'(1);
		end else if (32'(cfg_w_raw) > 32'(MAX_WIDTH)) begin
			cfg_w_eff = PW'(MAX_WIDTH);
		end else begin
			cfg_w_eff = PW'(cfg_w_raw);
		end
		cfg_h_eff = (cfg_data == '0) ? HW'(1) : cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= PW'(RESET_W);
			wm1_q <= CW'(RESET_W - 1);
			h_q   <= tumf_pkg::RESET_HEIGHT;
			hm1_q <= tumf_pkg::RESET_HEIGHT - HW'(1);
			thr_q <= tumf_pkg::RESET_THRESHOLD;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tumf_pkg::REG_FRAME_WIDTH: begin
					w_q   <= cfg_w_eff;
					wm1_q <= CW'(cfg_w_eff - PW'(1));
				end
				tumf_pkg::REG_FRAME_HEIGHT: begin
					h_q   <= cfg_h_eff;
					hm1_q <= cfg_h_eff - HW'(1);
				end
				tumf_pkg::REG_THRESHOLD: begin
					thr_q <= cfg_data[tumf_pkg::PIX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// raster counters
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] out_col_q;
	logic [HW-1:0] out_row_q;
	logic [PW-1:0] dly_ptr_q;

	// stage 1 and output register
	logic               v1_q;
	tumf_pkg::s1_ctrl_t ctrl_s1;
	logic [1:0]         line_rd_s1;
	logic               dly_rd_s1;

	logic                       res_valid_q;
	logic [tumf_pkg::PIX_W-1:0] res_pixel_q;
	logic                       res_last_q;

	logic               accept;
	logic               real_px;
	logic               take;
	logic               mbit;
	logic               xbit;
	logic               emit;
	logic               last;
	logic               out_load;
	logic               s1_go;
	logic               s1_free;
	logic               out_bit;
	logic [PW-1:0]      dly_addr;
	tumf_pkg::s1_ctrl_t ctrl_s0;

	always_comb begin
		out_load = !res_valid_q || result.ready;
		s1_go    = v1_q && (!ctrl_s1.emit || out_load);
		s1_free  = !v1_q || s1_go;

		pixels.ready = s1_free;
		accept  = pixels.valid && s1_free;
		real_px = in_row_q < {1'b0, h_q};
		// pad word inside the frame is dropped
		take    = accept && !(real_px && pixels.action);
		mbit    = real_px && (pixels.marker_pixel > thr_q);
		xbit    = real_px && (pixels.original_pixel > thr_q);

		// pointer left past the row by a smaller width restarts at slot zero
		dly_addr = (dly_ptr_q > w_q) ? '0 : dly_ptr_q;

		emit = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
		last = emit && (out_row_q >= hm1_q) && (out_col_q >= wm1_q);

		ctrl_s0.emit      = emit;
		ctrl_s0.mbit      = mbit;
		ctrl_s0.snew      = in_row_q[0];
		ctrl_s0.first_col = out_col_q == '0;
		ctrl_s0.last_col  = out_col_q >= wm1_q;
		ctrl_s0.first_row = out_row_q == '0;
		ctrl_s0.last_row  = out_row_q >= hm1_q;
		ctrl_s0.last      = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			dly_ptr_q <= '0;
		end else if (take) begin
			if (last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				dly_ptr_q <= '0;
			end else begin
				if (in_col_q >= wm1_q) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				dly_ptr_q <= (dly_addr >= w_q) ? '0 : dly_addr + PW'(1);
				if (emit) begin
					if (out_col_q >= wm1_q) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + HW'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

	// line memory: bit 0 row parity 0, bit 1 row parity 1; read-first
	logic [1:0] line_mem [MAX_WIDTH];
	logic       dly_mem  [MAX_WIDTH + 1];

	always_ff @(posedge clk) begin
		if (take) begin
			line_rd_s1 <= line_mem[in_col_q];
			if (in_row_q[0]) begin
				line_mem[in_col_q][1] <= mbit;
			end else begin
				line_mem[in_col_q][0] <= mbit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dly_rd_s1         <= dly_mem[dly_addr];
			dly_mem[dly_addr] <= xbit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (s1_free) begin
			v1_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctrl_s1 <= ctrl_s0;
		end
	end

	tumf_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (s1_go),
		.ctrl      (ctrl_s1),
		.line_bits (line_rd_s1),
		.delay_bit (dly_rd_s1),
		.out_bit   (out_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= s1_go && ctrl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && s1_go && ctrl_s1.emit) begin
			res_pixel_q <= out_bit ? tumf_pkg::PIX_ONE : tumf_pkg::PIX_ZERO;
			res_last_q  <= ctrl_s1.last;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.out_pixel     = res_pixel_q;
	assign result.last_of_frame = res_last_q;

endmodule

`default_nettype wire
